>>> rtl/assert_macros.svh
// Assertion macros used by the controller of the Fock matrix builder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define FMB_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define FMB_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

>>> rtl/fmb_pkg.sv
// Package for the Fock matrix builder: sizes, codes, command struct, chi rules.
// Depends on nothing.
package fmb_pkg;

   localparam int ORB_PER_ATOM = 4;
   localparam int MAX_ATOMS    = 8;
   localparam int SIDE         = 32;
   localparam int IDX_BITS     = $clog2(SIDE);
   localparam int ADDR_BITS    = 2 * IDX_BITS;
   localparam int DEPTH        = SIDE * SIDE;
   localparam int ORB_BITS     = (ORB_PER_ATOM > 1) ? $clog2(ORB_PER_ATOM) : 1;
   localparam int DIM_BITS     = IDX_BITS + 1;
   localparam int ATOM_BITS    = 4;
   localparam int ATOMS_USED   = (MAX_ATOMS < SIDE / ORB_PER_ATOM) ? MAX_ATOMS
                                                                  : SIDE / ORB_PER_ATOM;
   localparam int WORD_BITS    = 32;
   localparam int VALUE_BITS   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int LIMBS        = 4;
   localparam int LIMB_BITS    = 2;
   localparam int PROD_BITS    = LIMBS * WORD_BITS;
   localparam int ACC_BITS     = 192;
   localparam int H_SHIFT      = 3 * FRAC_BITS;

   localparam logic [1:0] KIND_LOAD_H   = 2'd0;
   localparam logic [1:0] KIND_LOAD_D   = 2'd1;
   localparam logic [1:0] KIND_LOAD_I   = 2'd2;
   localparam logic [1:0] KIND_COMPUTE  = 2'd3;

   localparam logic CSR_ATOM_COUNT  = 1'b0;
   localparam logic CSR_DIPOLE_GAIN = 1'b1;

   typedef enum logic [1:0] {CHI_ZERO, CHI_ONE, CHI_GAIN} chi_type;

   typedef enum logic [2:0] {
      DP_NOP, DP_STORE_H, DP_STORE_D, DP_STORE_I, DP_LOAD_H, DP_PROD, DP_GMUL, DP_ACC
   } dp_op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_H_READ, ST_H_LOAD, ST_SCAN, ST_PROD, ST_GMUL, ST_ACC, ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      dp_op_type             op;
      logic [LIMB_BITS-1:0]  limb;
      logic [ADDR_BITS-1:0]  h_addr;
      logic [ADDR_BITS-1:0]  i_addr;
      logic [ADDR_BITS-1:0]  d_addr;
      logic                  negate;
      logic                  dbl;
      logic [1:0]            ones;
      logic                  emit;
      logic [IDX_BITS-1:0]   row;
      logic [IDX_BITS-1:0]   col;
      logic                  last;
   } dp_cmd_type;

   function automatic logic [ORB_BITS-1:0] orb_of(input logic [IDX_BITS-1:0] idx);
      return ORB_BITS'(idx % ORB_PER_ATOM);
   endfunction

   function automatic logic [IDX_BITS-1:0] base_of(input logic [IDX_BITS-1:0] idx);
      return idx - IDX_BITS'(idx % ORB_PER_ATOM);
   endfunction

   // Orbital zero is the s orbital; all others are p orbitals.
   function automatic chi_type chi_code(input logic [ORB_BITS-1:0] o1,
                                        input logic [ORB_BITS-1:0] o2,
                                        input logic [ORB_BITS-1:0] o3);
      chi_type c;
      c = CHI_ZERO;
      if (o1 == o2 && o3 == '0) c = CHI_ONE;
      else if (o1 == o3 && o3 != '0 && o2 == '0) c = CHI_GAIN;
      else if (o2 == o3 && o3 != '0 && o1 == '0) c = CHI_GAIN;
      return c;
   endfunction

   function automatic logic [DIM_BITS-1:0] dim_of(input logic [ATOM_BITS-1:0] atoms);
      logic [ATOM_BITS-1:0] a;
      a = atoms;
      if (a == '0) a = ATOM_BITS'(1);
      if (a > ATOM_BITS'(ATOMS_USED)) a = ATOM_BITS'(ATOMS_USED);
      return DIM_BITS'(a * ORB_PER_ATOM);
   endfunction

endpackage

>>> rtl/fock_matrix_builder_unit.sv
// Channel   Ports                                          Handshake
// req       req_kind, req_row_index, req_col_index,         start & !busy
//           req_element_value
// rsp       rsp_out_row, rsp_out_col, rsp_fock_value,       rsp_strobe, one cycle each
//           rsp_last_of_row
// csr       csr_index, csr_wdata                            csr_we
//
// A load beat is stored as it is accepted. A compute beat for a row below n
// emits one result per column; a column loads the Hamiltonian, walks the
// Coulomb index space if on the row's own atom, then the exchange index space,
// and forms and accumulates each nonzero term, with its gain factors, on the one
// shared 32x32 multiplier. Reset is synchronous and clears control state only;
// matrix memories hold their contents. The receiver cannot stall results.
// Depends on fmb_pkg, fmb_csr, fmb_ctrl and fmb_datapath.
module fock_matrix_builder_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_kind,
   input  logic [fmb_pkg::IDX_BITS-1:0]   req_row_index,
   input  logic [fmb_pkg::IDX_BITS-1:0]   req_col_index,
   input  logic [fmb_pkg::WORD_BITS-1:0]  req_element_value,
   output logic                           rsp_strobe,
   output logic [fmb_pkg::IDX_BITS-1:0]   rsp_out_row,
   output logic [fmb_pkg::IDX_BITS-1:0]   rsp_out_col,
   output logic [fmb_pkg::VALUE_BITS-1:0] rsp_fock_value,
   output logic                           rsp_last_of_row,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [fmb_pkg::WORD_BITS-1:0]  csr_wdata
);

   logic [fmb_pkg::ATOM_BITS-1:0] atom_count;
   logic [fmb_pkg::WORD_BITS-1:0] dipole_gain;
   fmb_pkg::dp_cmd_type           cmd;

   fmb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .atom_count  (atom_count),
      .dipole_gain (dipole_gain)
   );

   fmb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_kind      (req_kind),
      .req_row_index (req_row_index),
      .atom_count    (atom_count),
      .busy          (busy),
      .cmd           (cmd)
   );

   fmb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .dipole_gain       (dipole_gain),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_fock_value    (rsp_fock_value),
      .rsp_last_of_row   (rsp_last_of_row)
   );

endmodule

>>> rtl/fmb_csr.sv
// Configuration registers of the Fock matrix builder: atom count and dipole gain.
// Depends on fmb_pkg.
module fmb_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [fmb_pkg::WORD_BITS-1:0]  csr_wdata,
   output logic [fmb_pkg::ATOM_BITS-1:0]  atom_count,
   output logic [fmb_pkg::WORD_BITS-1:0]  dipole_gain
);

   logic [fmb_pkg::ATOM_BITS-1:0] atom_count_ff;
   logic [fmb_pkg::WORD_BITS-1:0] dipole_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         atom_count_ff  <= fmb_pkg::ATOM_BITS'(1);
         dipole_gain_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            fmb_pkg::CSR_ATOM_COUNT:
               atom_count_ff <= csr_wdata[fmb_pkg::ATOM_BITS-1:0];
            fmb_pkg::CSR_DIPOLE_GAIN:
               dipole_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign atom_count  = atom_count_ff;
   assign dipole_gain = dipole_gain_ff;

endmodule

>>> rtl/fmb_datapath.sv
// Datapath of the Fock matrix builder: the three matrix memories, the shared
// 32x32 multiplier, the 192-bit accumulator and the result register.
// Depends on fmb_pkg.
module fmb_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  fmb_pkg::dp_cmd_type            cmd,
   input  logic [fmb_pkg::IDX_BITS-1:0]   req_row_index,
   input  logic [fmb_pkg::IDX_BITS-1:0]   req_col_index,
   input  logic [fmb_pkg::WORD_BITS-1:0]  req_element_value,
   input  logic [fmb_pkg::WORD_BITS-1:0]  dipole_gain,
   output logic                           rsp_strobe,
   output logic [fmb_pkg::IDX_BITS-1:0]   rsp_out_row,
   output logic [fmb_pkg::IDX_BITS-1:0]   rsp_out_col,
   output logic [fmb_pkg::VALUE_BITS-1:0] rsp_fock_value,
   output logic                           rsp_last_of_row
);

   localparam int W = fmb_pkg::WORD_BITS;
   localparam int SAT_LSB = fmb_pkg::H_SHIFT + fmb_pkg::VALUE_BITS - 1;

   logic [W-1:0] h_mem [fmb_pkg::DEPTH];
   logic [W-1:0] d_mem [fmb_pkg::DEPTH];
   logic [W-1:0] i_mem [fmb_pkg::DEPTH];

   logic [W-1:0] h_rd_ff, d_rd_ff, i_rd_ff;
   logic [fmb_pkg::ACC_BITS-1:0]  acc_ff, acc_in;
   logic [fmb_pkg::PROD_BITS-1:0] prod_ff, prod_in, tmp_ff, tmp_in;
   logic                          neg_ff, neg_in;
   logic                          strobe_ff;
   logic [fmb_pkg::IDX_BITS-1:0]  row_ff, col_ff;
   logic [fmb_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic                          last_ff;

   logic [fmb_pkg::ADDR_BITS-1:0] wr_addr;
   logic [W-1:0]                  abs_i, abs_d, abs_g, mul_a, mul_b;
   logic [2*W-1:0]                part;
   logic [fmb_pkg::PROD_BITS-1:0] part_sh, limb_sum;
   logic [5:0]                    shamt;
   logic [fmb_pkg::ACC_BITS-1:0]  term;
   logic                          sat_ok;

   assign wr_addr = {req_row_index, req_col_index};

   always_ff @(posedge clock) begin
      if (cmd.op == fmb_pkg::DP_STORE_H) h_mem[wr_addr] <= req_element_value;
      if (cmd.op == fmb_pkg::DP_STORE_D) d_mem[wr_addr] <= req_element_value;
      if (cmd.op == fmb_pkg::DP_STORE_I) i_mem[wr_addr] <= req_element_value;
      h_rd_ff <= h_mem[cmd.h_addr];
      d_rd_ff <= d_mem[cmd.d_addr];
      i_rd_ff <= i_mem[cmd.i_addr];
   end

   assign abs_i = i_rd_ff[W-1] ? (~i_rd_ff + W'(1)) : i_rd_ff;
   assign abs_d = d_rd_ff[W-1] ? (~d_rd_ff + W'(1)) : d_rd_ff;
   assign abs_g = dipole_gain[W-1] ? (~dipole_gain + W'(1)) : dipole_gain;

   // The one multiplier forms I times D, then one limb of the running
   // magnitude times the gain magnitude per cycle.
   assign mul_a    = (cmd.op == fmb_pkg::DP_GMUL) ? prod_ff[cmd.limb*W +: W] : abs_i;
   assign mul_b    = (cmd.op == fmb_pkg::DP_GMUL) ? abs_g : abs_d;
   assign part     = mul_a * mul_b;
   assign part_sh  = {{(fmb_pkg::PROD_BITS-2*W){1'b0}}, part} << (cmd.limb * W);
   assign limb_sum = tmp_ff + part_sh;

   assign shamt = {cmd.ones, 4'b0000} + 6'(cmd.dbl);
   assign term  = {{(fmb_pkg::ACC_BITS-fmb_pkg::PROD_BITS){1'b0}}, prod_ff} << shamt;

   // Floor to Q16.16 and clamp to the signed value range.
   assign sat_ok = (&acc_ff[fmb_pkg::ACC_BITS-1:SAT_LSB]) |
                   ~(|acc_ff[fmb_pkg::ACC_BITS-1:SAT_LSB]);

   always_comb begin
      acc_in  = acc_ff;
      prod_in = prod_ff;
      tmp_in  = tmp_ff;
      neg_in  = neg_ff;
      unique case (cmd.op)
         fmb_pkg::DP_LOAD_H:
            acc_in = {{(fmb_pkg::ACC_BITS-W-fmb_pkg::H_SHIFT){h_rd_ff[W-1]}},
                      h_rd_ff, {fmb_pkg::H_SHIFT{1'b0}}};
         fmb_pkg::DP_PROD: begin
            prod_in = {{(fmb_pkg::PROD_BITS-2*W){1'b0}}, part};
            tmp_in  = '0;
            neg_in  = i_rd_ff[W-1] ^ d_rd_ff[W-1];
         end
         fmb_pkg::DP_GMUL: begin
            if (cmd.limb == fmb_pkg::LIMB_BITS'(fmb_pkg::LIMBS - 1)) begin
               prod_in = limb_sum;
               tmp_in  = '0;
               neg_in  = neg_ff ^ dipole_gain[W-1];
            end else begin
               tmp_in = limb_sum;
            end
         end
         fmb_pkg::DP_ACC:
            acc_in = (neg_ff ^ cmd.negate) ? (acc_ff - term) : (acc_ff + term);
         default: ;
      endcase
      if (sat_ok)
         value_in = acc_ff[fmb_pkg::H_SHIFT +: fmb_pkg::VALUE_BITS];
      else if (acc_ff[fmb_pkg::ACC_BITS-1])
         value_in = {1'b1, {(fmb_pkg::VALUE_BITS-1){1'b0}}};
      else
         value_in = {1'b0, {(fmb_pkg::VALUE_BITS-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      tmp_ff  <= tmp_in;
      neg_ff  <= neg_in;
      if (cmd.emit) begin
         row_ff   <= cmd.row;
         col_ff   <= cmd.col;
         value_ff <= value_in;
         last_ff  <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= cmd.emit;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_fock_value  = value_ff;
   assign rsp_last_of_row = last_ff;

endmodule

>>> rtl/fmb_ctrl.sv
// Controller of the Fock matrix builder: walks columns and the Coulomb and
// exchange index spaces, skips zero chi terms and sequences the datapath.
// Depends on fmb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fmb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [1:0]                    req_kind,
   input  logic [fmb_pkg::IDX_BITS-1:0]  req_row_index,
   input  logic [fmb_pkg::ATOM_BITS-1:0] atom_count,
   output logic                          busy,
   output fmb_pkg::dp_cmd_type           cmd
);

   localparam int IB = fmb_pkg::IDX_BITS;
   localparam int OB = fmb_pkg::ORB_BITS;
   localparam logic [OB-1:0] ORB_MAX = OB'(fmb_pkg::ORB_PER_ATOM - 1);

   fmb_pkg::ctl_state_type state_ff, state_in;
   logic [IB-1:0] p_ff, p_in, q_ff, q_in, i1_ff, i1_in;
   logic [OB-1:0] i0_ff, i0_in, i2_ff, i2_in, i3_ff, i3_in;
   logic          coul_ff, coul_in;
   logic [1:0]    gains_ff, gains_in, ones_ff, ones_in;
   logic [fmb_pkg::LIMB_BITS-1:0] limb_ff, limb_in;

   logic [fmb_pkg::DIM_BITS-1:0] n;
   logic [IB-1:0] n_last, lim1, bp, bq, br;
   logic [OB-1:0] op, oq, ou_x;
   fmb_pkg::chi_type ca, cb;
   logic          l0, l1, l2, l3, adv_done, accept, col_last;
   logic [IB-1:0] i_row, i_col, d_row, d_col;

   assign n      = fmb_pkg::dim_of(atom_count);
   assign n_last = IB'(n - fmb_pkg::DIM_BITS'(1));
   assign accept = start && (state_ff == fmb_pkg::ST_IDLE);
   assign busy   = (state_ff != fmb_pkg::ST_IDLE);

   assign op   = fmb_pkg::orb_of(p_ff);
   assign oq   = fmb_pkg::orb_of(q_ff);
   assign bp   = fmb_pkg::base_of(p_ff);
   assign bq   = fmb_pkg::base_of(q_ff);
   assign br   = fmb_pkg::base_of(i1_ff);
   assign ou_x = i1_ff[OB-1:0];
   assign col_last = (q_ff == n_last);

   // Coulomb walk: i0 = t, i1 = r, i2 = s, i3 = u.
   // Exchange walk: i0 = s, i1 = u, i2 = r, i3 = t.
   always_comb begin
      if (coul_ff) begin
         ca    = fmb_pkg::chi_code(op, oq, i0_ff);
         cb    = fmb_pkg::chi_code(fmb_pkg::orb_of(i1_ff), i2_ff, i3_ff);
         i_row = bp + IB'(i0_ff);
         i_col = br + IB'(i3_ff);
         d_row = i1_ff;
         d_col = br + IB'(i2_ff);
      end else begin
         ca    = fmb_pkg::chi_code(op, i0_ff, ou_x);
         cb    = fmb_pkg::chi_code(i2_ff, oq, i3_ff);
         i_row = bq + IB'(i3_ff);
         i_col = bp + IB'(ou_x);
         d_row = bq + IB'(i2_ff);
         d_col = bp + IB'(i0_ff);
      end
   end

   assign lim1 = coul_ff ? n_last : IB'(fmb_pkg::ORB_PER_ATOM - 1);
   assign l0 = (i0_ff == ORB_MAX);
   assign l1 = (i1_ff == lim1);
   assign l2 = (i2_ff == ORB_MAX);
   assign l3 = (i3_ff == ORB_MAX);
   assign adv_done = l0 && l1 && l2 && l3;

   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      i0_in    = i0_ff;
      i1_in    = i1_ff;
      i2_in    = i2_ff;
      i3_in    = i3_ff;
      coul_in  = coul_ff;
      gains_in = gains_ff;
      ones_in  = ones_ff;
      limb_in  = limb_ff;

      cmd        = '0;
      cmd.op     = fmb_pkg::DP_NOP;
      cmd.h_addr = {p_ff, q_ff};
      cmd.i_addr = {i_row, i_col};
      cmd.d_addr = {d_row, d_col};
      cmd.limb   = limb_ff;
      cmd.ones   = ones_ff;
      cmd.negate = !coul_ff;
      cmd.dbl    = coul_ff;
      cmd.row    = p_ff;
      cmd.col    = q_ff;
      cmd.last   = col_last;

      unique case (state_ff)
         fmb_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  fmb_pkg::KIND_LOAD_H: cmd.op = fmb_pkg::DP_STORE_H;
                  fmb_pkg::KIND_LOAD_D: cmd.op = fmb_pkg::DP_STORE_D;
                  fmb_pkg::KIND_LOAD_I: cmd.op = fmb_pkg::DP_STORE_I;
                  default: begin
                     p_in = req_row_index;
                     q_in = '0;
                     if (fmb_pkg::DIM_BITS'(req_row_index) < n)
                        state_in = fmb_pkg::ST_H_READ;
                  end
               endcase
            end
         end
         fmb_pkg::ST_H_READ:
            state_in = fmb_pkg::ST_H_LOAD;
         fmb_pkg::ST_H_LOAD: begin
            cmd.op   = fmb_pkg::DP_LOAD_H;
            coul_in  = (bp == bq);
            i0_in    = '0;
            i1_in    = '0;
            i2_in    = '0;
            i3_in    = '0;
            state_in = fmb_pkg::ST_SCAN;
         end
         fmb_pkg::ST_SCAN, fmb_pkg::ST_ACC: begin
            if (state_ff == fmb_pkg::ST_ACC) cmd.op = fmb_pkg::DP_ACC;
            if (state_ff == fmb_pkg::ST_SCAN &&
                ca != fmb_pkg::CHI_ZERO && cb != fmb_pkg::CHI_ZERO) begin
               ones_in  = 2'(ca == fmb_pkg::CHI_ONE) + 2'(cb == fmb_pkg::CHI_ONE);
               gains_in = 2'(ca == fmb_pkg::CHI_GAIN) + 2'(cb == fmb_pkg::CHI_GAIN);
               state_in = fmb_pkg::ST_PROD;
            end else begin
               state_in = fmb_pkg::ST_SCAN;
               if (!adv_done) begin
                  i3_in = l3 ? '0 : i3_ff + OB'(1);
                  if (l3) i2_in = l2 ? '0 : i2_ff + OB'(1);
                  if (l3 && l2) i1_in = l1 ? '0 : i1_ff + IB'(1);
                  if (l3 && l2 && l1) i0_in = i0_ff + OB'(1);
               end else if (coul_ff) begin
                  coul_in = 1'b0;
                  i0_in   = '0;
                  i1_in   = '0;
                  i2_in   = '0;
                  i3_in   = '0;
               end else begin
                  state_in = fmb_pkg::ST_EMIT;
               end
            end
         end
         fmb_pkg::ST_PROD: begin
            cmd.op   = fmb_pkg::DP_PROD;
            limb_in  = '0;
            state_in = (gains_ff != 2'd0) ? fmb_pkg::ST_GMUL : fmb_pkg::ST_ACC;
         end
         fmb_pkg::ST_GMUL: begin
            cmd.op = fmb_pkg::DP_GMUL;
            if (limb_ff == fmb_pkg::LIMB_BITS'(fmb_pkg::LIMBS - 1)) begin
               limb_in  = '0;
               gains_in = gains_ff - 2'd1;
               if (gains_ff == 2'd1) state_in = fmb_pkg::ST_ACC;
            end else begin
               limb_in = limb_ff + fmb_pkg::LIMB_BITS'(1);
            end
         end
         fmb_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            if (col_last) begin
               state_in = fmb_pkg::ST_IDLE;
            end else begin
               q_in     = q_ff + IB'(1);
               state_in = fmb_pkg::ST_H_READ;
            end
         end
         default: state_in = fmb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= fmb_pkg::ST_IDLE;
      else       state_ff <= state_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      i0_ff    <= i0_in;
      i1_ff    <= i1_in;
      i2_ff    <= i2_in;
      i3_ff    <= i3_in;
      coul_ff  <= coul_in;
      gains_ff <= gains_in;
      ones_ff  <= ones_in;
      limb_ff  <= limb_in;
   end

   `FMB_ASSERT(a_compute_starts, clock, reset,
      (accept && req_kind == fmb_pkg::KIND_COMPUTE &&
       fmb_pkg::DIM_BITS'(req_row_index) < n) |=> (state_ff == fmb_pkg::ST_H_READ),
      "compute item in range did not start a row")
   `FMB_NEVER(a_gmul_has_gain, clock, reset,
      (state_ff == fmb_pkg::ST_GMUL && gains_ff == 2'd0),
      "gain multiply step with no gain factor left")
   `FMB_ASSERT(a_last_ends_row, clock, reset,
      (state_ff == fmb_pkg::ST_EMIT && col_last) |=> (state_ff == fmb_pkg::ST_IDLE),
      "row did not end after its last column")

endmodule
